// ===== rtl/mgfw_pkg.sv =====
// Shared widths, register map and reset values for the grid feature weight block.
package mgfw_pkg;

  // Field widths
  localparam int COORD_W  = 32;
  localparam int SCALE_W  = 32;
  localparam int STEPS_W  = 24;
  localparam int STEP_W   = 8;
  localparam int STRIDE_W = 2 * STEP_W;
  localparam int IDX_W    = 24;
  localparam int WGT_W    = 17;
  localparam int MAX_DIMS = 3;

  // Register port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [2:0] {
    REG_ORIGIN_0   = 3'd0,
    REG_ORIGIN_1   = 3'd1,
    REG_ORIGIN_2   = 3'd2,
    REG_SCALE_0    = 3'd3,
    REG_SCALE_1    = 3'd4,
    REG_SCALE_2    = 3'd5,
    REG_GRID_STEPS = 3'd6
  } reg_idx_t;

  // Reset values
  localparam logic [COORD_W-1:0] ORIGIN_RST = '0;
  localparam logic [SCALE_W-1:0] SCALE_RST  = 32'h0001_0000;
  localparam logic [STEPS_W-1:0] STEPS_RST  = 24'h02_0202;

  // Smallest usable steps count per dimension
  localparam logic [STEP_W-1:0] STEP_MIN = 8'd2;

  // Weight of one in the result format
  localparam logic [WGT_W-1:0] WGT_ONE = 17'h1_0000;

  typedef logic signed [COORD_W-1:0] coord_t;

endpackage

// ===== rtl/mgfw_in_if.sv =====
// Input point channel: valid/ready with three signed Q16.16 coordinates.
interface mgfw_in_if import mgfw_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t coord_0;
  coord_t coord_1;
  coord_t coord_2;

  modport source (output valid, output coord_0, output coord_1, output coord_2,
                  input ready);
  modport sink   (input valid, input coord_0, input coord_1, input coord_2,
                  output ready);
endinterface

// ===== rtl/mgfw_out_if.sv =====
// Result channel: valid/ready with feature index, weight and last flag.
interface mgfw_out_if import mgfw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] feature_index;
  logic [WGT_W-1:0] weight;
  logic             last;

  modport source (output valid, output feature_index, output weight, output last,
                  input ready);
  modport sink   (input valid, input feature_index, input weight, input last,
                  output ready);
endinterface

// ===== rtl/multilinear_grid_feature_weights.sv =====
// Top level: multilinear grid interpolation weights, deep pipeline with result expander.
//
//  channel  | direction | beat contents
//  ---------+-----------+---------------------------------------------------
//  in_ch    | sink      | coord_0..coord_2, signed Q16.16 point
//  out_ch   | source    | feature_index, weight (Q0.16), last
//  cfg      | APB slave | origin_0..2, scale_0..2, grid_steps at 4*index
//
// One point yields 2^DIMS result beats, one per cycle while out_ch does not stall,
// so a point holds the single result port for 2^DIMS beats (8 for three dimensions).
// The first result passes the registers diff, multiply, clamp, stride term,
// expander, two weight multiplies and output register, in that order.
// Reset (synchronous) restores the register reset values and empties the pipe.
// A stall on out_ch holds every stage; ready runs back stage by stage to in_ch.
module multilinear_grid_feature_weights import mgfw_pkg::*; #(
  parameter int DIMS      = 3,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  mgfw_in_if.sink           in_ch,
  mgfw_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int ACTS     = 1 << DIMS;
  localparam int K_W      = DIMS;
  localparam int SHIFT    = COORD_W - FRAC_BITS;
  localparam int PROD_W   = 2 * COORD_W;
  localparam int GP_W     = PROD_W - SHIFT;
  localparam int MAXPOS_W = STEP_W + FRAC_BITS;
  localparam int FAC_W    = FRAC_BITS + 1;
  localparam int WS_DN    = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int WS_UP    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int RND_DN   = (WS_DN > 0) ? (1 << (WS_DN - 1)) : 0;
  localparam int CV_W     = FAC_W + WS_UP + 1;

  localparam logic [FAC_W-1:0]   ONE_F  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [2*FAC_W-1:0] HALF_P = (2*FAC_W)'(1) << (FRAC_BITS - 1);

  // Q0.F multiply, rounded half up back to F fraction bits
  function automatic logic [FAC_W-1:0] mul_round(input logic [FAC_W-1:0] a,
                                                 input logic [FAC_W-1:0] b);
    logic [2*FAC_W-1:0] p;
    p = (2*FAC_W)'(a) * (2*FAC_W)'(b);
    p = p + HALF_P;
    return p[FRAC_BITS +: FAC_W];
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  coord_t               origin_r [MAX_DIMS];
  logic [SCALE_W-1:0]   scale_r  [MAX_DIMS];
  logic [STEPS_W-1:0]   grid_steps_r;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        origin_r[d] <= ORIGIN_RST;
        scale_r[d]  <= SCALE_RST;
      end
      grid_steps_r <= STEPS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ORIGIN_0:   origin_r[0]  <= pwdata;
        REG_ORIGIN_1:   origin_r[1]  <= pwdata;
        REG_ORIGIN_2:   origin_r[2]  <= pwdata;
        REG_SCALE_0:    scale_r[0]   <= pwdata;
        REG_SCALE_1:    scale_r[1]   <= pwdata;
        REG_SCALE_2:    scale_r[2]   <= pwdata;
        REG_GRID_STEPS: grid_steps_r <= pwdata[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      REG_ORIGIN_0:   prdata = origin_r[0];
      REG_ORIGIN_1:   prdata = origin_r[1];
      REG_ORIGIN_2:   prdata = origin_r[2];
      REG_SCALE_0:    prdata = scale_r[0];
      REG_SCALE_1:    prdata = scale_r[1];
      REG_SCALE_2:    prdata = scale_r[2];
      REG_GRID_STEPS: prdata = {{(APB_DW-STEPS_W){1'b0}}, grid_steps_r};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Grid geometry from the steps register (static while items flow)
  // ---------------------------------------------------------------------
  logic [STEP_W-1:0]   steps      [DIMS];
  logic [STRIDE_W-1:0] stride_nxt [DIMS];
  logic [STRIDE_W-1:0] stride_r   [DIMS];
  logic [MAXPOS_W-1:0] maxpos_nxt [DIMS];
  logic [MAXPOS_W-1:0] maxpos_r   [DIMS];

  always_comb begin
    logic [STRIDE_W+STEP_W-1:0] sp;
    sp = '0;
    for (int d = 0; d < DIMS; d++) begin
      // steps byte below two counts as two
      steps[d] = (grid_steps_r[d*STEP_W +: STEP_W] < STEP_MIN) ? STEP_MIN
                                                               : grid_steps_r[d*STEP_W +: STEP_W];
      maxpos_nxt[d] = {steps[d] - STEP_W'(1), {FRAC_BITS{1'b0}}} - MAXPOS_W'(1);
    end
    stride_nxt[0] = STRIDE_W'(1);
    for (int d = 1; d < DIMS; d++) begin
      sp            = (STRIDE_W+STEP_W)'(stride_nxt[d-1]) * (STRIDE_W+STEP_W)'(steps[d-1]);
      stride_nxt[d] = sp[STRIDE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < DIMS; d++) begin
      stride_r[d] <= stride_nxt[d];
      maxpos_r[d] <= maxpos_nxt[d];
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake: each stage loads when empty or when it drains
  // ---------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, ex_v_r, w1_v_r, w2_v_r, o_v_r;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, ex_rdy, w1_rdy, w2_rdy, o_rdy;
  logic ex_adv, ex_done;
  logic [K_W-1:0] ex_k_r;

  assign o_rdy   = ~o_v_r  | out_ch.ready;
  assign w2_rdy  = ~w2_v_r | o_rdy;
  assign w1_rdy  = ~w1_v_r | w2_rdy;
  assign ex_adv  = ex_v_r & w1_rdy;
  assign ex_done = ex_adv & (ex_k_r == K_W'(ACTS - 1));
  assign ex_rdy  = ~ex_v_r | ex_done;
  assign s4_rdy  = ~s4_v_r | ex_rdy;
  assign s3_rdy  = ~s3_v_r | s4_rdy;
  assign s2_rdy  = ~s2_v_r | s3_rdy;
  assign s1_rdy  = ~s1_v_r | s2_rdy;

  assign in_ch.ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      ex_v_r <= 1'b0;
      ex_k_r <= '0;
      w1_v_r <= 1'b0;
      w2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_ch.valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
      if (s4_rdy) s4_v_r <= s3_v_r;
      if (ex_rdy) begin
        ex_v_r <= s4_v_r;
        ex_k_r <= '0;
      end else if (ex_adv) begin
        ex_k_r <= ex_k_r + K_W'(1);
      end
      if (w1_rdy) w1_v_r <= ex_v_r;
      if (w2_rdy) w2_v_r <= w1_v_r;
      if (o_rdy)  o_v_r  <= w2_v_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: offset from origin
  // ---------------------------------------------------------------------
  coord_t               coord_in  [MAX_DIMS];
  logic [COORD_W:0]     diff      [DIMS];
  logic                 s1_pos_r  [DIMS];
  logic [COORD_W-1:0]   s1_mag_r  [DIMS];

  always_comb begin
    coord_in[0] = in_ch.coord_0;
    coord_in[1] = in_ch.coord_1;
    coord_in[2] = in_ch.coord_2;
    for (int d = 0; d < DIMS; d++) begin
      diff[d] = {coord_in[d][COORD_W-1], coord_in[d]} - {origin_r[d][COORD_W-1], origin_r[d]};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      for (int d = 0; d < DIMS; d++) begin
        // zero or negative offset lands on position zero
        s1_pos_r[d] <= ~diff[d][COORD_W] & (diff[d] != '0);
        s1_mag_r[d] <= diff[d][COORD_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: offset times reciprocal spacing, exact Q32.32
  // ---------------------------------------------------------------------
  logic [PROD_W-1:0] s2_prod_r [DIMS];

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      for (int d = 0; d < DIMS; d++) begin
        s2_prod_r[d] <= s1_pos_r[d] ? PROD_W'(s1_mag_r[d]) * PROD_W'(scale_r[d]) : '0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: truncate, clamp to the last cell, split cell / fraction
  // ---------------------------------------------------------------------
  logic [GP_W-1:0]      gp          [DIMS];
  logic [MAXPOS_W-1:0]  gpc         [DIMS];
  logic [STEP_W-1:0]    s3_cell_r   [DIMS];
  logic [FRAC_BITS-1:0] s3_frac_r   [DIMS];

  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      gp[d]  = s2_prod_r[d][PROD_W-1:SHIFT];
      gpc[d] = (gp[d] > GP_W'(maxpos_r[d])) ? maxpos_r[d] : gp[d][MAXPOS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      for (int d = 0; d < DIMS; d++) begin
        s3_cell_r[d] <= gpc[d][MAXPOS_W-1:FRAC_BITS];
        s3_frac_r[d] <= gpc[d][FRAC_BITS-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: cell times stride per dimension
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0]     s4_term_r [DIMS];
  logic [FRAC_BITS-1:0] s4_frac_r [DIMS];

  always_ff @(posedge clk) begin
    if (s4_rdy) begin
      for (int d = 0; d < DIMS; d++) begin
        s4_term_r[d] <= IDX_W'(s3_cell_r[d]) * IDX_W'(stride_r[d]);
        s4_frac_r[d] <= s3_frac_r[d];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Expander: holds one point, walks the 2^DIMS cell corners
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0]     ex_base_nxt;
  logic [IDX_W-1:0]     ex_base_r;
  logic [FRAC_BITS-1:0] ex_frac_r [DIMS];
  logic [IDX_W-1:0]     ex_idx;
  logic [FAC_W-1:0]     ex_fac [MAX_DIMS];

  always_comb begin
    ex_base_nxt = '0;
    for (int d = 0; d < DIMS; d++) begin
      ex_base_nxt = ex_base_nxt + s4_term_r[d];
    end
  end

  always_ff @(posedge clk) begin
    if (ex_rdy) begin
      ex_base_r <= ex_base_nxt;
      for (int d = 0; d < DIMS; d++) begin
        ex_frac_r[d] <= s4_frac_r[d];
      end
    end
  end

  // corner bit set: right edge, fraction; clear: left edge, one minus fraction
  always_comb begin
    ex_idx = ex_base_r;
    for (int d = 0; d < MAX_DIMS; d++) begin
      ex_fac[d] = ONE_F;
    end
    for (int d = 0; d < DIMS; d++) begin
      if (ex_k_r[d]) begin
        ex_idx    = ex_idx + IDX_W'(stride_r[d]);
        ex_fac[d] = {1'b0, ex_frac_r[d]};
      end else begin
        ex_fac[d] = ONE_F - {1'b0, ex_frac_r[d]};
      end
    end
  end

  // ---------------------------------------------------------------------
  // Weight stages: one rounded multiply each; unused dims multiply by one
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0] w1_idx_r, w2_idx_r;
  logic [FAC_W-1:0] w1_wgt_r, w2_wgt_r;
  logic [FAC_W-1:0] w1_fac_r;
  logic             w1_last_r, w2_last_r;

  always_ff @(posedge clk) begin
    if (w1_rdy) begin
      w1_idx_r  <= ex_idx;
      w1_wgt_r  <= mul_round(ex_fac[0], ex_fac[1]);
      w1_fac_r  <= ex_fac[2];
      w1_last_r <= (ex_k_r == K_W'(ACTS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (w2_rdy) begin
      w2_idx_r  <= w1_idx_r;
      w2_wgt_r  <= mul_round(w1_wgt_r, w1_fac_r);
      w2_last_r <= w1_last_r;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: weight rescaled to Q0.16
  // ---------------------------------------------------------------------
  logic [CV_W-1:0]  wgt_cv;
  logic [IDX_W-1:0] o_idx_r;
  logic [WGT_W-1:0] o_wgt_r;
  logic             o_last_r;

  assign wgt_cv = ((CV_W'(w2_wgt_r) + CV_W'(RND_DN)) >> WS_DN) << WS_UP;

  always_ff @(posedge clk) begin
    if (o_rdy) begin
      o_idx_r  <= w2_idx_r;
      o_wgt_r  <= wgt_cv[WGT_W-1:0];
      o_last_r <= w2_last_r;
    end
  end

  assign out_ch.valid         = o_v_r;
  assign out_ch.feature_index = o_idx_r;
  assign out_ch.weight        = o_wgt_r;
  assign out_ch.last          = o_last_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  logic [K_W-1:0] out_cnt_r;

  // result beats delivered, modulo 2^DIMS
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_cnt_r <= '0;
    end else if (out_ch.valid && out_ch.ready) begin
      out_cnt_r <= out_cnt_r + K_W'(1);
    end
  end

  a_last_every_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.last == (&out_cnt_r)))
    else $error("last flag out of step with result count");

  a_weight_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.weight <= WGT_ONE))
    else $error("weight above one");

  a_expander_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_rdy && s4_v_r) |=> (ex_v_r && (ex_k_r == '0)))
    else $error("expander did not restart at corner zero");

  for (genvar g = 0; g < DIMS; g++) begin : g_cell_chk
    a_cell_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
      s3_v_r |-> (s3_cell_r[g] <= maxpos_r[g][MAXPOS_W-1:FRAC_BITS]))
      else $error("clamped cell beyond last grid cell");
  end

endmodule
